// ----- rtl/psm_pkg.sv -----
// Shared widths, payload structs and a helper function of the planar shadow matrix core.
// No dependencies; every other file of the block imports this package.
package psm_pkg;

  localparam int PW    = 32;
  localparam int VW    = 33;
  localparam int MAGW  = 66;
  localparam int MW    = 31;
  localparam int SUMW  = 64;
  localparam int LENW  = 32;
  localparam int LW    = 7;
  localparam int CW    = 36;
  localparam int PRODW = 68;
  localparam int EW    = 70;
  localparam int OUTW  = 48;

  typedef struct packed {
    logic                    degen;
    logic [2:0]              neg;
    logic [2:0][MW-1:0]      mag;
    logic [2:0][PW-1:0]      p2;
  } psm_norm_t;

  typedef struct packed {
    logic                    degen;
    logic [2:0][CW-1:0]      c;
    logic [2:0][PW-1:0]      p2;
  } psm_coef_t;

  typedef struct packed {
    logic                      degen;
    logic [3:0][3:0][PRODW-1:0] p;
    logic [EW-1:0]             dot;
  } psm_mat_t;

  function automatic logic [LW-1:0] psm_bitlen(input logic [MAGW-1:0] x);
    logic [LW-1:0] l;
    l = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (x[i]) l = LW'(i + 1);
    end
    return l;
  endfunction

endpackage

// ----- rtl/psm_front.sv -----
// Front end: edge vectors, cross product, magnitude scaling and sum of squares.
// Seven register stages; depends on psm_pkg.
module psm_front import psm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0][PW-1:0] p0_i,
  input  logic [2:0][PW-1:0] p1_i,
  input  logic [2:0][PW-1:0] p2_i,
  output logic               valid_o,
  output logic [SUMW-1:0]    sum_o,
  output psm_norm_t          side_o
);

  logic [6:0] valid_q;

  logic signed [VW-1:0]     v1_q [3];
  logic signed [VW-1:0]     v2_q [3];
  logic [2:0][PW-1:0]       p2a_q, p2b_q, p2c_q, p2d_q;
  logic signed [2*VW-1:0]   pa_q [3];
  logic signed [2*VW-1:0]   pb_q [3];
  logic [MAGW-1:0]          mag3_q [3];
  logic [MAGW-1:0]          mag4_q [3];
  logic [2:0]               neg3_q, neg4_q;
  logic                     degen3_q, degen4_q;
  logic [LW-1:0]            bl_q;
  psm_norm_t                s5_q, s6_q, s7_q;
  logic [2*MW-1:0]          sq_q [3];
  logic [SUMW-1:0]          sum_q;

  logic signed [VW+2*VW-VW:0] n_d [3];
  logic [MAGW-1:0]            mag_d [3];
  logic [2:0]                 neg_d;
  logic [MW-1:0]              m_d [3];
  logic [MAGW-1:0]            sh_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_d[k]   = {pa_q[k][2*VW-1], pa_q[k]} - {pb_q[k][2*VW-1], pb_q[k]};
      neg_d[k] = n_d[k][2*VW];
      mag_d[k] = neg_d[k] ? MAGW'(-n_d[k]) : MAGW'(n_d[k]);
      if (bl_q > LW'(MW)) begin
        sh_d[k] = mag4_q[k] >> (bl_q - LW'(MW));
      end else begin
        sh_d[k] = mag4_q[k] << (LW'(MW) - bl_q);
      end
      m_d[k] = sh_d[k][MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        v1_q[k] <= VW'($signed(p0_i[k])) - VW'($signed(p1_i[k]));
        v2_q[k] <= VW'($signed(p1_i[k])) - VW'($signed(p2_i[k]));
      end
      p2a_q <= p2_i;
      pa_q[0] <= v1_q[1] * v2_q[2];
      pb_q[0] <= v1_q[2] * v2_q[1];
      pa_q[1] <= v1_q[2] * v2_q[0];
      pb_q[1] <= v1_q[0] * v2_q[2];
      pa_q[2] <= v1_q[0] * v2_q[1];
      pb_q[2] <= v1_q[1] * v2_q[0];
      p2b_q <= p2a_q;
      for (int k = 0; k < 3; k++) begin
        mag3_q[k] <= mag_d[k];
      end
      neg3_q   <= neg_d;
      degen3_q <= (mag_d[0] == '0) && (mag_d[1] == '0) && (mag_d[2] == '0);
      p2c_q    <= p2b_q;
      bl_q     <= psm_bitlen(mag3_q[0] | mag3_q[1] | mag3_q[2]);
      for (int k = 0; k < 3; k++) begin
        mag4_q[k] <= mag3_q[k];
      end
      neg4_q   <= neg3_q;
      degen4_q <= degen3_q;
      p2d_q    <= p2c_q;
      s5_q.degen <= degen4_q;
      s5_q.neg   <= neg4_q;
      s5_q.p2    <= p2d_q;
      for (int k = 0; k < 3; k++) begin
        s5_q.mag[k] <= m_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (2*MW)'(s5_q.mag[k]) * (2*MW)'(s5_q.mag[k]);
      end
      s6_q  <= s5_q;
      sum_q <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
      s7_q  <= s6_q;
    end
  end

  assign valid_o = valid_q[6];
  assign sum_o   = sum_q;
  assign side_o  = s7_q;

endmodule

// ----- rtl/psm_sqrt.sv -----
// Pipelined integer square root of the sum of squares, four bit pairs per stage.
// Eight register stages; depends on psm_pkg.
module psm_sqrt import psm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SUMW-1:0] sum_i,
  input  psm_norm_t       side_i,
  output logic            valid_o,
  output logic [LENW-1:0] len_o,
  output psm_norm_t       side_o
);

  localparam int Steps  = 4;
  localparam int Stages = SUMW / (2 * Steps);

  logic [Stages-1:0] valid_q;
  logic [SUMW-1:0]   v_q [Stages];
  logic [SUMW-1:0]   r_q [Stages];
  psm_norm_t         side_q [Stages];
  logic [SUMW-1:0]   v_d [Stages];
  logic [SUMW-1:0]   r_d [Stages];

  always_comb begin
    logic [SUMW-1:0] v, r, b, t;
    for (int s = 0; s < Stages; s++) begin
      v = (s == 0) ? sum_i : v_q[(s == 0) ? 0 : s - 1];
      r = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < Steps; j++) begin
        b = SUMW'(1) << (SUMW - 2 - 2 * (s * Steps + j));
        t = r + b;
        if (v >= t) begin
          v = v - t;
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      v_d[s] = v;
      r_d[s] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Stages; s++) begin
        v_q[s]    <= v_d[s];
        r_q[s]    <= r_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign len_o   = r_q[Stages-1][LENW-1:0];
  assign side_o  = side_q[Stages-1];

endmodule

// ----- rtl/psm_div.sv -----
// Three-lane pipelined restoring divider giving the rounded unit normal components.
// One set-up stage plus four quotient bits per stage; depends on psm_pkg.
module psm_div import psm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [LENW-1:0] len_i,
  input  psm_norm_t       side_i,
  output logic            valid_o,
  output psm_coef_t       coef_o
);

  localparam int QB   = ((FRAC_BITS + 4) / 4) * 4;
  localparam int Stgs = QB / 4;
  localparam int NWD  = MW + FRAC_BITS + 1;

  logic [Stgs:0]   valid_q;
  logic [LENW-1:0] rem_q [Stgs+1][3];
  logic [QB-1:0]   lo_q  [Stgs+1][3];
  logic [LENW-1:0] len_q [Stgs+1];
  psm_norm_t       side_q [Stgs+1];
  logic [LENW-1:0] rem_d [Stgs+1][3];
  logic [QB-1:0]   lo_d  [Stgs+1][3];

  always_comb begin
    logic [NWD-1:0]  n, sh;
    logic [LENW:0]   t;
    logic [LENW-1:0] rem;
    logic [QB-1:0]   lo;
    for (int k = 0; k < 3; k++) begin
      n  = (NWD'(side_i.mag[k]) << FRAC_BITS) + NWD'(len_i >> 1);
      sh = n >> QB;
      rem_d[0][k] = sh[LENW-1:0];
      lo_d[0][k]  = n[QB-1:0];
    end
    for (int s = 1; s <= Stgs; s++) begin
      for (int k = 0; k < 3; k++) begin
        rem = rem_q[s-1][k];
        lo  = lo_q[s-1][k];
        for (int j = 0; j < 4; j++) begin
          t  = {rem, lo[QB-1]};
          lo = {lo[QB-2:0], 1'b0};
          if (t >= {1'b0, len_q[s-1]}) begin
            t     = t - {1'b0, len_q[s-1]};
            lo[0] = 1'b1;
          end
          rem = t[LENW-1:0];
        end
        rem_d[s][k] = rem;
        lo_d[s][k]  = lo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stgs-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s <= Stgs; s++) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[s][k] <= rem_d[s][k];
          lo_q[s][k]  <= lo_d[s][k];
        end
        len_q[s]  <= (s == 0) ? len_i : len_q[(s == 0) ? 0 : s - 1];
        side_q[s] <= (s == 0) ? side_i : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_comb begin
    coef_o.degen = side_q[Stgs].degen;
    coef_o.p2    = side_q[Stgs].p2;
    for (int k = 0; k < 3; k++) begin
      coef_o.c[k] = side_q[Stgs].neg[k] ? (CW'(0) - CW'(lo_q[Stgs][k])) : CW'(lo_q[Stgs][k]);
    end
  end

  assign valid_o = valid_q[Stgs];

endmodule

// ----- rtl/psm_back.sv -----
// Back end: plane offset D, light products and the diagonal dot term.
// Four register stages; depends on psm_pkg.
module psm_back import psm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  psm_coef_t          coef_i,
  input  logic [3:0][PW-1:0] light_i,
  output logic               valid_o,
  output psm_mat_t           mat_o
);

  localparam logic signed [EW-1:0] Half = EW'(1) << (FRAC_BITS - 1);

  logic [3:0]              valid_q;
  logic signed [CW-1:0]    c1_q [3];
  logic signed [PRODW-1:0] dp_q [3];
  logic                    dg1_q, dg2_q, dg3_q;
  logic signed [CW-1:0]    c2_q [4];
  logic signed [PRODW-1:0] p_q [4][4];
  psm_mat_t                mat_q;
  logic signed [EW-1:0]    dsum_d, rnd_d, dot_d;

  always_comb begin
    dsum_d = EW'(dp_q[0]) + EW'(dp_q[1]) + EW'(dp_q[2]);
    rnd_d  = (dsum_d + Half) >>> FRAC_BITS;
    dot_d  = EW'(p_q[0][0]) + EW'(p_q[1][1]) + EW'(p_q[2][2]) + EW'(p_q[3][3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        c1_q[k] <= $signed(coef_i.c[k]);
        dp_q[k] <= $signed(coef_i.c[k]) * $signed(coef_i.p2[k]);
        c2_q[k] <= c1_q[k];
      end
      dg1_q   <= coef_i.degen;
      c2_q[3] <= CW'(-rnd_d);
      dg2_q   <= dg1_q;
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          p_q[j][i] <= $signed(light_i[j]) * c2_q[i];
        end
      end
      dg3_q <= dg2_q;
      mat_q.degen <= dg3_q;
      mat_q.dot   <= dot_d;
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          mat_q.p[j][i] <= p_q[j][i];
        end
      end
    end
  end

  assign valid_o = valid_q[3];
  assign mat_o   = mat_q;

endmodule

// ----- rtl/psm_colout.sv -----
// Column sequencer: holds one matrix, rounds and saturates one column per unstalled cycle
// into the output register, and drives the pipeline advance; depends on psm_pkg.
module psm_colout import psm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  psm_mat_t             mat_i,
  input  logic                 out_stall_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  output logic [1:0]           column_o,
  output logic [3:0][OUTW-1:0] rows_o,
  output logic                 last_o,
  output logic                 degen_o
);

  localparam logic signed [EW-1:0] Half   = EW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] SatMax = {{(EW-OUTW+1){1'b0}}, {(OUTW-1){1'b1}}};
  localparam logic signed [EW-1:0] SatMin = ~SatMax;

  logic                 h_valid_q, out_valid_q;
  psm_mat_t             h_q;
  logic [1:0]           col_q, column_q;
  logic [3:0][OUTW-1:0] rows_q, rows_d;
  logic                 last_q, degen_q;
  logic                 out_ld;
  logic signed [EW-1:0] e, rnd;

  assign out_ld = !out_valid_q || !out_stall_i;
  assign en_o   = !h_valid_q || (out_ld && (col_q == 2'd3));

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (col_q == 2'(r)) begin
        e = $signed(h_q.dot) - EW'($signed(h_q.p[col_q][r]));
      end else begin
        e = -EW'($signed(h_q.p[col_q][r]));
      end
      rnd = (e + Half) >>> FRAC_BITS;
      if (h_q.degen) begin
        rows_d[r] = '0;
      end else if (rnd > SatMax) begin
        rows_d[r] = SatMax[OUTW-1:0];
      end else if (rnd < SatMin) begin
        rows_d[r] = SatMin[OUTW-1:0];
      end else begin
        rows_d[r] = rnd[OUTW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
    end else begin
      if (out_ld && h_valid_q) begin
        col_q <= col_q + 2'd1;
      end
      if (en_o) begin
        h_valid_q <= valid_i;
      end
      if (out_ld) begin
        out_valid_q <= h_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      h_q <= mat_i;
    end
    if (out_ld) begin
      column_q <= col_q;
      rows_q   <= rows_d;
      last_q   <= (col_q == 2'd3);
      degen_q  <= h_q.degen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign column_o    = column_q;
  assign rows_o      = rows_q;
  assign last_o      = last_q;
  assign degen_o     = degen_q;

endmodule

// ----- rtl/planar_shadow_matrix_core.sv -----
// Top level of the planar shadow matrix core: light registers and the pipeline chain.
// Depends on psm_pkg, psm_front, psm_sqrt, psm_div, psm_back and psm_colout.
//
//   channel   signals                                   direction
//   config    cfg_we_i, cfg_index_i, cfg_data_i         in, write only
//   points    in_valid_i / in_stall_o, p0..p2 x,y,z     in
//   columns   out_valid_o / out_stall_i, column, rows   out, four items per input item
//
// An item passes through the front, sqrt, divider and back pipelines and the sequencer's
// holding register to its first column; the columns then follow one per unstalled cycle.
// The four-column sequencer takes a new matrix only as the held one gives its last column.
// Reset clears all valid bits and loads the default light position.
// Output stall holds the output register and, once the held matrix is finished, freezes the
// whole pipeline, which then stalls the input.
module planar_shadow_matrix_core import psm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [PW-1:0]          cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PW-1:0]   p0_x_i,
  input  logic signed [PW-1:0]   p0_y_i,
  input  logic signed [PW-1:0]   p0_z_i,
  input  logic signed [PW-1:0]   p1_x_i,
  input  logic signed [PW-1:0]   p1_y_i,
  input  logic signed [PW-1:0]   p1_z_i,
  input  logic signed [PW-1:0]   p2_x_i,
  input  logic signed [PW-1:0]   p2_y_i,
  input  logic signed [PW-1:0]   p2_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             column_o,
  output logic signed [OUTW-1:0] row0_value_o,
  output logic signed [OUTW-1:0] row1_value_o,
  output logic signed [OUTW-1:0] row2_value_o,
  output logic signed [OUTW-1:0] row3_value_o,
  output logic                   last_column_o,
  output logic                   degenerate_o
);

  localparam logic [2:0] RegLightX = 3'd0;
  localparam logic [2:0] RegLightY = 3'd1;
  localparam logic [2:0] RegLightZ = 3'd2;
  localparam logic [2:0] RegLightW = 3'd3;

  localparam logic [PW-1:0] RstX = PW'(-(64'sd50 <<< FRAC_BITS));
  localparam logic [PW-1:0] RstY = PW'(64'sd50 <<< FRAC_BITS);
  localparam logic [PW-1:0] RstZ = PW'(64'sd100 <<< FRAC_BITS);
  localparam logic [PW-1:0] RstW = PW'(64'sd1 <<< FRAC_BITS);

  logic [3:0][PW-1:0]   light_q;
  logic                 en;
  logic                 f_valid, s_valid, d_valid, b_valid;
  logic [SUMW-1:0]      sum;
  psm_norm_t            f_side, s_side;
  logic [LENW-1:0]      len;
  psm_coef_t            coef;
  psm_mat_t             mat;
  logic [3:0][OUTW-1:0] rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q[0] <= RstX;
      light_q[1] <= RstY;
      light_q[2] <= RstZ;
      light_q[3] <= RstW;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLightX: light_q[0] <= cfg_data_i;
        RegLightY: light_q[1] <= cfg_data_i;
        RegLightZ: light_q[2] <= cfg_data_i;
        RegLightW: light_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !en;

  psm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .p0_i    ({p0_z_i, p0_y_i, p0_x_i}),
    .p1_i    ({p1_z_i, p1_y_i, p1_x_i}),
    .p2_i    ({p2_z_i, p2_y_i, p2_x_i}),
    .valid_o (f_valid),
    .sum_o   (sum),
    .side_o  (f_side)
  );

  psm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .sum_i   (sum),
    .side_i  (f_side),
    .valid_o (s_valid),
    .len_o   (len),
    .side_o  (s_side)
  );

  psm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .len_i   (len),
    .side_i  (s_side),
    .valid_o (d_valid),
    .coef_o  (coef)
  );

  psm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .coef_i  (coef),
    .light_i (light_q),
    .valid_o (b_valid),
    .mat_o   (mat)
  );

  psm_colout #(.FRAC_BITS(FRAC_BITS)) u_colout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (b_valid),
    .mat_i       (mat),
    .out_stall_i (out_stall_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .column_o    (column_o),
    .rows_o      (rows),
    .last_o      (last_column_o),
    .degen_o     (degenerate_o)
  );

  assign row0_value_o = rows[0];
  assign row1_value_o = rows[1];
  assign row2_value_o = rows[2];
  assign row3_value_o = rows[3];

endmodule

// ----- sim/planar_shadow_matrix_core_test.sv -----
// Testbench of planar_shadow_matrix_core: random and directed plane points, checked
// column by column against a predictor of the shadow matrix held in a scoreboard class.
// Depends on psm_pkg and the RTL of the block only.
module planar_shadow_matrix_core_test;
  import psm_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [PW-1:0] pts_t [9];

  typedef enum logic [2:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_LIGHT_W = 3'd3,
    REG_SPARE   = 3'd5
  } light_reg_e;

  typedef struct {
    logic [1:0]        column;
    logic [OUTW-1:0]   rows [4];
    logic              last;
    logic              degen;
  } column_t;

  class shadow_board;
    wide_t   light [4];
    column_t columns_due [$];
    int      mismatches;

    function new();
      light[0] = -3276800;
      light[1] = 3276800;
      light[2] = 6553600;
      light[3] = 65536;
      mismatches = 0;
    endfunction

    function void set_light(input int idx, input logic [PW-1:0] d);
      if (idx < 4) light[idx] = {{96{d[31]}}, d};
    endfunction

    function int waiting();
      return columns_due.size();
    endfunction

    function logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function wide_t round_frac(input wide_t e);
      return (e + wide_t'(32768)) >>> 16;
    endfunction

    function logic [OUTW-1:0] clamp48(input wide_t e);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< 47) - 1;
      lo = -(wide_t'(1) <<< 47);
      if (e > hi) return hi[OUTW-1:0];
      if (e < lo) return lo[OUTW-1:0];
      return e[OUTW-1:0];
    endfunction

    function void note_points(input pts_t p);
      wide_t pv [9];
      wide_t v1 [3], v2 [3], n [3], a [3], c [4], prod [4], dot, e;
      logic [63:0] s [3];
      logic [63:0] sum, len, q;
      logic degen;
      int bl, big;
      column_t col;
      for (int i = 0; i < 9; i++) pv[i] = {{96{p[i][31]}}, p[i]};
      for (int k = 0; k < 3; k++) begin
        v1[k] = pv[k] - pv[3+k];
        v2[k] = pv[3+k] - pv[6+k];
      end
      n[0] = v1[1] * v2[2] - v1[2] * v2[1];
      n[1] = v1[2] * v2[0] - v1[0] * v2[2];
      n[2] = v1[0] * v2[1] - v1[1] * v2[0];
      degen = 1'b1;
      big = 0;
      for (int k = 0; k < 3; k++) begin
        a[k] = n[k] < 0 ? -n[k] : n[k];
        if (a[k] != 0) degen = 1'b0;
        bl = 0;
        for (int i = 0; i < 128; i++) if (a[k][i]) bl = i + 1;
        if (bl > big) big = bl;
      end
      if (!degen) begin
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          if (big > 31) s[k] = 64'(a[k] >> (big - 31));
          else s[k] = 64'(a[k] << (31 - big));
          sum = sum + s[k] * s[k];
        end
        len = int_sqrt(sum);
        dot = 0;
        for (int k = 0; k < 3; k++) begin
          q = ((s[k] << 16) + len / 2) / len;
          c[k] = n[k] < 0 ? -wide_t'(q) : wide_t'(q);
          dot = dot + c[k] * pv[6+k];
        end
        c[3] = -round_frac(dot);
        for (int k = 0; k < 4; k++) prod[k] = light[k] * c[k];
      end
      for (int k = 0; k < 4; k++) begin
        col.column = k[1:0];
        col.last = (k == 3);
        col.degen = degen;
        for (int r = 0; r < 4; r++) begin
          if (degen) begin
            col.rows[r] = '0;
          end else begin
            if (r == k) e = prod[0] + prod[1] + prod[2] + prod[3] - prod[k];
            else e = -(light[k] * c[r]);
            col.rows[r] = clamp48(round_frac(e));
          end
        end
        columns_due.push_back(col);
      end
    endfunction

    function void check_column(input column_t got);
      column_t want;
      if (columns_due.size() == 0) begin
        $error("column item with nothing expected: column %0d", got.column);
        mismatches++;
        return;
      end
      want = columns_due.pop_front();
      if (got.column !== want.column) begin
        $error("column: expected %0d, actual %0d", want.column, got.column);
        mismatches++;
      end
      for (int r = 0; r < 4; r++) begin
        if (got.rows[r] !== want.rows[r]) begin
          $error("row%0d_value: expected %0d, actual %0d", r,
                 $signed(want.rows[r]), $signed(got.rows[r]));
          mismatches++;
        end
      end
      if (got.last !== want.last) begin
        $error("last_column: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
      if (got.degen !== want.degen) begin
        $error("degenerate: expected %0b, actual %0b", want.degen, got.degen);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [PW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [PW-1:0] p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i;
  logic signed [PW-1:0] p2_x_i, p2_y_i, p2_z_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] column_o;
  logic signed [OUTW-1:0] row0_value_o, row1_value_o, row2_value_o, row3_value_o;
  logic last_column_o, degenerate_o;

  shadow_board board = new();
  logic quiet;
  int   items_sent;

  planar_shadow_matrix_core DUT (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    column_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.column = column_o;
      got.rows[0] = row0_value_o;
      got.rows[1] = row1_value_o;
      got.rows[2] = row2_value_o;
      got.rows[3] = row3_value_o;
      got.last = last_column_o;
      got.degen = degenerate_o;
      board.check_column(got);
    end
  end

  initial begin
    int k;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      k = quiet ? 0 : $urandom_range(0, 6);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_points(input pts_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {p0_x_i, p0_y_i, p0_z_i} <= {p[0], p[1], p[2]};
    {p1_x_i, p1_y_i, p1_z_i} <= {p[3], p[4], p[5]};
    {p2_x_i, p2_y_i, p2_z_i} <= {p[6], p[7], p[8]};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_points(p);
    items_sent++;
  endtask

  task automatic write_light(input light_reg_e idx, input logic [PW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    board.set_light(int'(idx), d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.waiting() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [PW-1:0] pick_coord(input int kind);
    logic [PW-1:0] ends [5];
    ends = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
    case (kind)
      0: return PW'(($urandom_range(0, 4000) - 2000) <<< 16) ^ PW'($urandom_range(0, 65535));
      1: return $urandom();
      default: return ends[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic pts_t random_points();
    pts_t p;
    int kind, shape;
    logic [PW-1:0] d [3];
    shape = $urandom_range(0, 9);
    kind = shape < 5 ? 0 : (shape < 7 ? 1 : 2);
    for (int i = 0; i < 9; i++) p[i] = pick_coord(kind);
    if (shape == 8) begin
      for (int k = 0; k < 3; k++) begin
        d[k] = PW'($urandom_range(0, 2000)) - 1000;
        p[3+k] = p[k] + d[k] * 65536;
        p[6+k] = p[k] + d[k] * 131072;
      end
    end else if (shape == 9) begin
      for (int k = 0; k < 3; k++) begin
        p[3+k] = p[k];
        p[6+k] = p[k];
      end
    end
    return p;
  endfunction

  initial begin
    pts_t p;
    quiet = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_LIGHT_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    {p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i, p2_x_i, p2_y_i, p2_z_i} = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    p = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_points(p);
    p = '{0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000};
    send_points(p);
    p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_points(p);
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    send_points(p);
    p = '{32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 0};
    send_points(p);
    p = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
    send_points(p);
    p = '{0, 0, 0, 32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000};
    send_points(p);
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_points(p);
    p = '{32'hffffffff, 0, 32'h7fffffff, 0, 32'hffffffff, 32'h80000000, 32'h1, 32'h1, 0};
    send_points(p);
    for (int i = 0; i < 10; i++) send_points(random_points());

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_light(REG_LIGHT_X, 32'h7fffffff);
          write_light(REG_LIGHT_Y, 32'h7fffffff);
          write_light(REG_LIGHT_Z, 32'h7fffffff);
          write_light(REG_LIGHT_W, 32'h7fffffff);
        end
        1: begin
          write_light(REG_LIGHT_X, 32'h80000000);
          write_light(REG_LIGHT_Y, 32'h80000000);
          write_light(REG_LIGHT_Z, 32'h80000000);
          write_light(REG_LIGHT_W, 32'h80000000);
        end
        2: begin
          write_light(REG_LIGHT_X, 32'h0);
          write_light(REG_LIGHT_Y, 32'h0);
          write_light(REG_LIGHT_Z, 32'h0);
          write_light(REG_LIGHT_W, 32'h0);
          write_light(REG_SPARE, 32'h12345678);
        end
        default: begin
          write_light(REG_LIGHT_X, $urandom());
          write_light(REG_LIGHT_Y, PW'(($urandom_range(0, 400) - 200) <<< 16));
          write_light(REG_LIGHT_Z, $urandom());
          write_light(REG_LIGHT_W, phase == 5 ? 32'h10000 : $urandom());
        end
      endcase
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      for (int i = 0; i < 60; i++) begin
        quiet = (i >= 20 && i < 30);
        send_points(random_points());
      end
      quiet = 1'b0;
    end
    drain();

    $display("Sent %0d point sets over seven light settings, extremes included,", items_sent);
    $display("with random gaps and output stalls; collinear and coincident sets mixed in.");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
